>>> design/bdac_pkg.sv
// package for the binary to decimal ascii unit
// shared constants, controller state type and controller/datapath command and status structs
// no dependencies

package bdac_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_BITS    = 4 * NUM_DIGITS;
    localparam int CHAR_BITS   = 6;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS);

    // largest value that fits in the digit buffer, and a compare width that holds it
    localparam int SAT_BITS    = 34;
    localparam int CMP_BITS    = (VALUE_BITS > SAT_BITS) ? VALUE_BITS : SAT_BITS;
    localparam logic [CMP_BITS-1:0] SAT_LIMIT = CMP_BITS'(64'd9999999999);

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic load;       // capture a new value, clear the digit buffer
        logic dabble;     // one double-dabble step
        logic shift_dig;  // move the next digit to the top of the buffer
        logic out_load;   // capture the top digit into the output register
        logic out_last;   // flag for the captured digit
    } dp_cmd_t;

    typedef struct packed {
        logic top_zero;   // top digit of the buffer is zero
    } dp_status_t;

endpackage

>>> design/bdac_datapath.sv
// datapath of the binary to decimal ascii unit
// binary shift register, bcd digit buffer and output character register; uses bdac_pkg

module bdac_datapath (
    input  logic                              clk,
    input  logic [bdac_pkg::VALUE_BITS-1:0]   value,
    input  bdac_pkg::dp_cmd_t                 cmd,
    output bdac_pkg::dp_status_t              status,
    output logic [bdac_pkg::CHAR_BITS-1:0]    digit_char,
    output logic                              last
);
    import bdac_pkg::*;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [CHAR_BITS-1:0]  char_reg, char_next;
    logic                  last_reg, last_next;
    logic [CMP_BITS-1:0]   value_wide;
    logic [3:0]            top_digit;

    assign value_wide = CMP_BITS'(value);
    assign top_digit  = bcd_reg[BCD_BITS-1 -: 4];

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            // values beyond ten digits saturate
            if (value_wide > SAT_LIMIT)
                bin_next = SAT_LIMIT[VALUE_BITS-1:0];
            else
                bin_next = value;
            bcd_next = '0;
        end
        else if (cmd.dabble)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
        end
        else if (cmd.shift_dig)
        begin
            bcd_next = {bcd_reg[BCD_BITS-5:0], 4'd0};
        end
        if (cmd.out_load)
        begin
            char_next = ASCII_ZERO + CHAR_BITS'(top_digit);
            last_next = cmd.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.top_zero = (top_digit == 4'd0);
    assign digit_char      = char_reg;
    assign last            = last_reg;

endmodule

>>> design/bdac_ctrl.sv
// controller of the binary to decimal ascii unit
// sequences load, double-dabble steps and digit emission; owns both handshakes; uses bdac_pkg

module bdac_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  bdac_pkg::dp_status_t  status,
    output bdac_pkg::dp_cmd_t     cmd
);
    import bdac_pkg::*;

    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   is_final;
    logic                   out_free;

    assign is_final = (dig_cnt_reg == DIG_CNT_W'(NUM_DIGITS - 1));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1))
                begin
                    dig_cnt_next = '0;
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.top_zero && !started_reg && !is_final)
                begin
                    // leading zero, drop it
                    cmd.shift_dig = 1'b1;
                    dig_cnt_next  = dig_cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = is_final;
                    cmd.shift_dig = 1'b1;
                    started_next  = 1'b1;
                    dig_cnt_next  = dig_cnt_reg + 1'b1;
                    if (is_final)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/binary_to_decimal_ascii_unit.sv
// Binary to decimal ascii unit: takes one unsigned VALUE_BITS-wide value per item and returns
// its decimal digits as ascii characters '0'..'9', most significant first, leading zeros
// dropped, zero printed as a single '0', and last set on the final digit. Values above
// 9999999999 (possible only when VALUE_BITS exceeds 33) saturate to that number. One item
// is worked at a time: a load step, VALUE_BITS double-dabble steps (one input bit per
// cycle through ten parallel bcd digit adjusters), then one emission step per digit
// position of the buffer, ten in all; a digit that is shown waits while the output stalls.
// The final character sits in the output register while the next item is already
// accepted and converted.
// depends on bdac_pkg, bdac_ctrl and bdac_datapath

module binary_to_decimal_ascii_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bdac_pkg::VALUE_BITS-1:0]   value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bdac_pkg::CHAR_BITS-1:0]    digit_char,
    output logic                              last
);
    import bdac_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // controller: state machine, step and digit counters, output valid flag
    bdac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: binary shifter, bcd buffer, character register
    bdac_datapath u_dp (
        .clk        (clk),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .digit_char (digit_char),
        .last       (last)
    );

    // every character shown is a decimal digit
    a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_BITS'(9)))
        else $error("non-digit character on output");

    // conversion is busy the cycle after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accepting an item");

    // while waiting for an item, any pending character closes the previous run
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && out_valid) |-> last)
        else $error("idle with a non-final digit still pending");

endmodule
